[rtl/core/assert_macros.svh]
// Assertion macros shared by the vertex normal accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VNA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vna assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VNA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vna assertion failed");

`endif

[rtl/core/vna_pkg.sv]
// Package: constants, codes and types of the vertex normal accumulator.
`default_nettype none
package vna_pkg;

  localparam int ADDR_W     = 12;
  localparam int VERTICES   = 1 << ADDR_W;
  localparam int COORD_W    = 32;
  localparam int NRM_W      = 16;
  localparam int POS_ROW_W  = 3 * COORD_W;
  localparam int NRM_ROW_W  = 3 * NRM_W;
  localparam int VCOUNT_W   = 13;
  localparam int EDGE_FRAC  = 30;
  localparam int NORM_FRAC  = 14;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(VERTICES);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_NRD, S_PA, S_PB, S_PC, S_N1,
    S_E2, S_N2, S_CROSS, S_N3ST, S_N3, S_MRD, S_MWR, S_OUT
  } vna_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQUARE, N_ROOT, N_LOAD, N_DIV, N_DONE
  } norm_state_t;

  typedef struct packed {
    logic start;
    logic frac_norm;   // 1: Q1.14 result, 0: Q1.30 result
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic zero;        // input vector was all zero
  } norm_rsp_t;

endpackage
`default_nettype wire

[rtl/core/vna_if.sv]
// Channel interfaces: operation input, result output, configuration write.
`default_nettype none
interface vna_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [11:0]        corner_a;
  logic [11:0]        corner_b;
  logic [11:0]        corner_c;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               last_face;
  modport source (output valid, opcode, corner_a, corner_b, corner_c,
                  pos_x, pos_y, pos_z, last_face, input ready);
  modport sink   (input valid, opcode, corner_a, corner_b, corner_c,
                  pos_x, pos_y, pos_z, last_face, output ready);
endinterface

interface vna_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               pass_done;
  modport source (output valid, status, normal_x, normal_y, normal_z,
                  pass_done, input ready);
  modport sink   (input valid, status, normal_x, normal_y, normal_z,
                  pass_done, output ready);
endinterface

interface vna_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

[rtl/core/vna_ram.sv]
// Simple dual-port RAM: one write port, one read port, registered read data.
`default_nettype none
module vna_ram #(
  parameter int WIDTH  = 48,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/vna_norm.sv]
// Multi-cycle vector normalizer: shift, sum of squares, bit-serial root and divide.
`default_nettype none
`include "assert_macros.svh"
module vna_norm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  var  vna_pkg::norm_req_t    req_i,
  input  wire logic signed [63:0]    vec_i [3],
  output vna_pkg::norm_rsp_t         rsp_o,
  output logic signed [31:0]         res_o [3]
);
  import vna_pkg::*;

  norm_state_t        state_r, state_nxt;
  logic [63:0]        mag_r [3];
  logic [2:0]         neg_r;
  logic               frac_r;
  logic               zero_r;
  logic [4:0]         cnt_r;
  logic [1:0]         comp_r;
  logic [59:0]        prod_r;
  logic [63:0]        sum_r;
  logic [31:0]        root_r;
  logic [34:0]        rem_r;
  logic [32:0]        drem_r;
  logic [31:0]        numlo_r;
  logic [31:0]        q_r;
  logic signed [31:0] res_r [3];

  logic [63:0] or_all;
  logic        sh_r8, sh_r1, sh_l8, sh_l1;
  logic [29:0] sq_m;
  logic [34:0] rem_sh, trial;
  logic        root_ge;
  logic [29:0] div_m;
  logic [63:0] num;
  logic [32:0] dt;
  logic        div_ge;
  logic [31:0] q_fin, one, q_cl;

  always_comb begin
    or_all  = mag_r[0] | mag_r[1] | mag_r[2];
    sh_r8   = |or_all[63:38];
    sh_r1   = |or_all[63:30];
    sh_l8   = ~|or_all[63:21];
    sh_l1   = ~or_all[29];
    sq_m    = (cnt_r[1:0] == 2'd3) ? 30'd0 : mag_r[cnt_r[1:0]][29:0];
    rem_sh  = {rem_r[32:0], sum_r[63:62]};
    trial   = {1'b0, root_r, 2'b01};
    root_ge = rem_sh >= trial;
    div_m   = mag_r[comp_r][29:0];
    num     = (frac_r ? ({34'd0, div_m} << NORM_FRAC) : ({34'd0, div_m} << EDGE_FRAC))
              + {33'd0, root_r[31:1]};
    dt      = {drem_r[31:0], numlo_r[31]};
    div_ge  = dt >= {1'b0, root_r};
    q_fin   = {q_r[30:0], div_ge};
    one     = frac_r ? (32'd1 << NORM_FRAC) : (32'd1 << EDGE_FRAC);
    q_cl    = (q_fin > one) ? one : q_fin;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      N_IDLE:   if (req_i.start) state_nxt = N_SHIFT;
      N_SHIFT: begin
        if (or_all == 64'd0) begin
          state_nxt = N_DONE;
        end else if (!sh_r1 && !sh_l1) begin
          state_nxt = N_SQUARE;
        end
      end
      N_SQUARE: if (cnt_r == 5'd3) state_nxt = N_ROOT;
      N_ROOT:   if (cnt_r == 5'd31) state_nxt = N_LOAD;
      N_LOAD:   state_nxt = N_DIV;
      N_DIV: begin
        if (cnt_r == 5'd31) begin
          state_nxt = (comp_r == 2'd2) ? N_DONE : N_LOAD;
        end
      end
      N_DONE:   state_nxt = N_IDLE;
      default:  state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (req_i.start) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= vec_i[i][63] ? $unsigned(-vec_i[i]) : $unsigned(vec_i[i]);
            neg_r[i] <= vec_i[i][63];
          end
          frac_r <= req_i.frac_norm;
          zero_r <= 1'b0;
        end
      end
      N_SHIFT: begin
        if (or_all == 64'd0) begin
          zero_r <= 1'b1;
        end else if (sh_r8) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 8;
        end else if (sh_r1) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else if (sh_l8) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 8;
        end else if (sh_l1) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end else begin
          cnt_r <= 5'd0;
          sum_r <= 64'd0;
        end
      end
      N_SQUARE: begin
        prod_r <= sq_m * sq_m;
        if (cnt_r != 5'd0) sum_r <= sum_r + {4'd0, prod_r};
        if (cnt_r == 5'd3) begin
          cnt_r  <= 5'd0;
          root_r <= 32'd0;
          rem_r  <= 35'd0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      N_ROOT: begin
        rem_r  <= root_ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[30:0], root_ge};
        sum_r  <= sum_r << 2;
        cnt_r  <= cnt_r + 5'd1;
        comp_r <= 2'd0;
      end
      N_LOAD: begin
        drem_r  <= {1'b0, num[63:32]};
        numlo_r <= num[31:0];
        q_r     <= 32'd0;
        cnt_r   <= 5'd0;
      end
      N_DIV: begin
        drem_r  <= div_ge ? (dt - {1'b0, root_r}) : dt;
        numlo_r <= numlo_r << 1;
        q_r     <= q_fin;
        cnt_r   <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          res_r[comp_r] <= neg_r[comp_r] ? -$signed(q_cl) : $signed(q_cl);
          comp_r        <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_r == N_DONE);
  assign rsp_o.zero = zero_r;
  assign res_o      = res_r;

  `VNA_ASSERT_IMP(a_start_idle, req_i.start, state_r == N_IDLE)
  `VNA_ASSERT_NXT(a_root_range, state_r == N_ROOT && cnt_r == 5'd31, root_r[31:29] != 3'd0)
endmodule
`default_nettype wire

[rtl/core/vertex_normal_accumulator.sv]
// Top level: per-vertex normal accumulator with position and normal memories.
// Usage:
//   in_ch  carries one operation word: load a position (clears that vertex's
//          normal), apply a face, or read a vertex normal. Accepted when
//          valid and ready are both high.
//   out_ch returns exactly one result word per operation: status, normal,
//          and pass_done (last_face echoed on apply face).
//   cfg_ch writes vertex_count; always ready, write only while idle.
// An apply face finishes early when an edge or the cross product comes
//   out zero. One operation is in flight at a time; the face time is set
//   by the shared normalizer (bit-serial square root, three 32-step
//   divides) run three times, plus 3 position reads and 3 normal
//   read-modify-writes.
// Reset: vertex_count returns to 4096 and a clearing pass writes zero to
//   all 4096 normal entries with in_ch.ready held low.
// Stall: the result sits in an output register; the next word is accepted
//   while it waits, and the block holds in its output state until the
//   register frees.
`default_nettype none
`include "assert_macros.svh"
module vertex_normal_accumulator (
  input wire logic  clk,
  input wire logic  rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch,
  vna_cfg_if.sink   cfg_ch
);
  import vna_pkg::*;

  vna_state_t state_r, state_nxt;

  logic [VCOUNT_W-1:0]       vcount_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  op_t                       op_r;
  logic [ADDR_W-1:0]         ia_r, ib_r, ic_r;
  logic signed [COORD_W-1:0] px_r, py_r, pz_r;
  logic                      last_r;
  status_t                   status_r;
  logic signed [NRM_W-1:0]   nv_r [3];
  logic signed [COORD_W-1:0] pa_r [3], pb_r [3], pc_r [3];
  logic signed [31:0]        u1_r [3], u2_r [3];
  logic signed [63:0]        cr_r [3];
  logic signed [63:0]        prod_r;
  logic [2:0]                cnt_r;
  logic [1:0]                corner_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [NRM_W-1:0] out_nrm_r [3];
  logic                    out_pass_r;

  // memory ports
  logic                 pos_we, pos_re, nrm_we, nrm_re;
  logic [ADDR_W-1:0]    pos_waddr, pos_raddr, nrm_waddr, nrm_raddr;
  logic [POS_ROW_W-1:0] pos_wdata, pos_rdata;
  logic [NRM_ROW_W-1:0] nrm_wdata, nrm_rdata;

  // normalizer
  norm_req_t          norm_req;
  norm_rsp_t          norm_rsp;
  logic signed [63:0] norm_vec [3];
  logic signed [31:0] norm_res [3];

  logic                    in_acc, out_load;
  logic                    ok_a, ok_all;
  logic [ADDR_W-1:0]       corner_addr;
  logic signed [31:0]      mul_a, mul_b;
  logic [2:0]              acc_k;
  logic signed [NRM_W-1:0] merged [3];
  logic signed [NRM_W:0]   msum [3], mhalf [3];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // index below min(vertex_count, 4096); a 12-bit index never reaches 4096
  assign ok_a   = {1'b0, ia_r} < vcount_r;
  assign ok_all = ok_a && ({1'b0, ib_r} < vcount_r) && ({1'b0, ic_r} < vcount_r);

  always_comb begin
    case (corner_r)
      2'd0:    corner_addr = ia_r;
      2'd1:    corner_addr = ib_r;
      default: corner_addr = ic_r;
    endcase
  end

  // cross product term select: even terms add, odd terms subtract
  always_comb begin
    case (cnt_r)
      3'd0:    begin mul_a = u1_r[1]; mul_b = u2_r[2]; end
      3'd1:    begin mul_a = u1_r[2]; mul_b = u2_r[1]; end
      3'd2:    begin mul_a = u1_r[2]; mul_b = u2_r[0]; end
      3'd3:    begin mul_a = u1_r[0]; mul_b = u2_r[2]; end
      3'd4:    begin mul_a = u1_r[0]; mul_b = u2_r[1]; end
      3'd5:    begin mul_a = u1_r[1]; mul_b = u2_r[0]; end
      default: begin mul_a = 32'sd0;  mul_b = 32'sd0;  end
    endcase
  end
  assign acc_k = cnt_r - 3'd1;

  // merge of stored normal with face normal; halved sum truncates toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      msum[i]  = (NRM_W+1)'($signed(nrm_rdata[i*NRM_W +: NRM_W])) + (NRM_W+1)'(nv_r[i]);
      mhalf[i] = msum[i] + $signed({{NRM_W{1'b0}}, msum[i][NRM_W]});
      merged[i] = (nrm_rdata == '0) ? nv_r[i] : mhalf[i][NRM_W:1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (state_r)
        S_PC:    norm_vec[i] = 64'(pb_r[i]) - 64'(pa_r[i]);
        S_E2:    norm_vec[i] = 64'(pc_r[i]) - 64'(pa_r[i]);
        default: norm_vec[i] = cr_r[i];
      endcase
    end
  end

  // next state and memory / normalizer control
  always_comb begin
    state_nxt          = state_r;
    pos_we             = 1'b0;
    pos_waddr          = ia_r;
    pos_wdata          = {pz_r, py_r, px_r};
    pos_re             = 1'b0;
    pos_raddr          = ia_r;
    nrm_we             = 1'b0;
    nrm_waddr          = ia_r;
    nrm_wdata          = '0;
    nrm_re             = 1'b0;
    nrm_raddr          = ia_r;
    norm_req.start     = 1'b0;
    norm_req.frac_norm = 1'b0;
    out_load           = 1'b0;
    case (state_r)
      S_CLEAR: begin
        nrm_we    = 1'b1;
        nrm_waddr = clr_addr_r;
        if (clr_addr_r == {ADDR_W{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_acc) state_nxt = S_DECODE;
      S_DECODE: begin
        case (op_r)
          OP_LOAD: begin
            pos_we    = ok_a;
            nrm_we    = ok_a;
            state_nxt = S_OUT;
          end
          OP_FACE: begin
            pos_re    = ok_all;
            state_nxt = ok_all ? S_PA : S_OUT;
          end
          OP_READ: begin
            nrm_re    = ok_a;
            state_nxt = ok_a ? S_NRD : S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_NRD: state_nxt = S_OUT;
      S_PA: begin
        pos_re    = 1'b1;
        pos_raddr = ib_r;
        state_nxt = S_PB;
      end
      S_PB: begin
        pos_re    = 1'b1;
        pos_raddr = ic_r;
        state_nxt = S_PC;
      end
      S_PC: begin
        norm_req.start = 1'b1;
        state_nxt      = S_N1;
      end
      S_N1: if (norm_rsp.done) state_nxt = norm_rsp.zero ? S_OUT : S_E2;
      S_E2: begin
        norm_req.start = 1'b1;
        state_nxt      = S_N2;
      end
      S_N2: if (norm_rsp.done) state_nxt = norm_rsp.zero ? S_OUT : S_CROSS;
      S_CROSS: if (cnt_r == 3'd6) state_nxt = S_N3ST;
      S_N3ST: begin
        norm_req.start     = 1'b1;
        norm_req.frac_norm = 1'b1;
        state_nxt          = S_N3;
      end
      S_N3: if (norm_rsp.done) state_nxt = norm_rsp.zero ? S_OUT : S_MRD;
      S_MRD: begin
        nrm_re    = 1'b1;
        nrm_raddr = corner_addr;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        nrm_we    = 1'b1;
        nrm_waddr = corner_addr;
        nrm_wdata = {merged[2], merged[1], merged[0]};
        state_nxt = (corner_r == 2'd2) ? S_OUT : S_MRD;
      end
      S_OUT: begin
        out_load = !out_valid_r || out_ch.ready;
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      vcount_r   <= VCOUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_ch.valid) vcount_r <= cfg_ch.vertex_count;
    end
  end

  // operation datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r   <= op_t'(in_ch.opcode);
          ia_r   <= in_ch.corner_a;
          ib_r   <= in_ch.corner_b;
          ic_r   <= in_ch.corner_c;
          px_r   <= in_ch.pos_x;
          py_r   <= in_ch.pos_y;
          pz_r   <= in_ch.pos_z;
          last_r <= in_ch.last_face;
        end
      end
      S_DECODE: begin
        for (int i = 0; i < 3; i++) nv_r[i] <= '0;
        case (op_r)
          OP_LOAD: status_r <= ok_a ? ST_OK : ST_RANGE;
          OP_FACE: status_r <= ok_all ? ST_OK : ST_RANGE;
          OP_READ: status_r <= ok_a ? ST_OK : ST_RANGE;
          default: status_r <= ST_OK;
        endcase
      end
      S_NRD: for (int i = 0; i < 3; i++) nv_r[i] <= nrm_rdata[i*NRM_W +: NRM_W];
      S_PA:  for (int i = 0; i < 3; i++) pa_r[i] <= pos_rdata[i*COORD_W +: COORD_W];
      S_PB:  for (int i = 0; i < 3; i++) pb_r[i] <= pos_rdata[i*COORD_W +: COORD_W];
      S_PC:  for (int i = 0; i < 3; i++) pc_r[i] <= pos_rdata[i*COORD_W +: COORD_W];
      S_N1: begin
        if (norm_rsp.done) begin
          if (norm_rsp.zero) status_r <= ST_DEGEN;
          else u1_r <= norm_res;
        end
      end
      S_N2: begin
        cnt_r <= 3'd0;
        if (norm_rsp.done) begin
          if (norm_rsp.zero) status_r <= ST_DEGEN;
          else u2_r <= norm_res;
        end
      end
      S_CROSS: begin
        prod_r <= mul_a * mul_b;
        if (cnt_r != 3'd0) begin
          if (!acc_k[0]) cr_r[acc_k[2:1]] <= prod_r;
          else cr_r[acc_k[2:1]] <= cr_r[acc_k[2:1]] - prod_r;
        end
        cnt_r <= cnt_r + 3'd1;
      end
      S_N3: begin
        corner_r <= 2'd0;
        if (norm_rsp.done) begin
          if (norm_rsp.zero) begin
            status_r <= ST_DEGEN;
          end else begin
            for (int i = 0; i < 3; i++) nv_r[i] <= norm_res[i][NRM_W-1:0];
          end
        end
      end
      S_MWR: corner_r <= corner_r + 2'd1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_nrm_r    <= nv_r;
      out_pass_r   <= (op_r == OP_FACE) && last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.normal_x  = out_nrm_r[0];
  assign out_ch.normal_y  = out_nrm_r[1];
  assign out_ch.normal_z  = out_nrm_r[2];
  assign out_ch.pass_done = out_pass_r;

  vna_ram #(.WIDTH(POS_ROW_W), .ADDR_W(ADDR_W)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(.WIDTH(NRM_ROW_W), .ADDR_W(ADDR_W)) u_nrm_ram (
    .clk   (clk),
    .we    (nrm_we),
    .waddr (nrm_waddr),
    .wdata (nrm_wdata),
    .re    (nrm_re),
    .raddr (nrm_raddr),
    .rdata (nrm_rdata)
  );

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (norm_req),
    .vec_i (norm_vec),
    .rsp_o (norm_rsp),
    .res_o (norm_res)
  );

  `VNA_ASSERT_IMP(a_merge_ok, state_r == S_MWR, status_r == ST_OK)
  `VNA_ASSERT_IMP(a_degen_face, out_load && status_r == ST_DEGEN, op_r == OP_FACE)
  `VNA_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r && !norm_req.start)
endmodule
`default_nettype wire
